[rtl/cfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

   localparam int CHUNK_NUM  = 8;
   localparam int CHUNK_SIZE = 32;

   localparam int SLOT_W  = $clog2(CHUNK_NUM);
   localparam int FILL_W  = $clog2(CHUNK_SIZE + 2);
   localparam int ADDR_W  = $clog2(CHUNK_NUM * CHUNK_SIZE);
   localparam int BYTES   = CHUNK_NUM * CHUNK_SIZE;
   localparam int SUM_W   = (SLOT_W + 1 > 3) ? SLOT_W + 1 : 3;
   localparam int LENX_W  = (FILL_W > 6) ? FILL_W : 6;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_FULL     = 3'd1,
      ST_TOO_LONG = 3'd2,
      ST_POP_BYTE = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  in_byte;
      logic        in_last;
      logic [31:0] in_media_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic [31:0] out_media_id;
      logic [5:0]  out_len;
      logic        out_last;
      logic [2:0]  stored_count;
   } rsp_type;

   typedef struct packed {
      fill_type    len;
      logic [31:0] src_id;
   } desc_type;

   function automatic slot_type slot_next(input slot_type s);
      slot_type r;
      if (s == SLOT_W'(CHUNK_NUM - 1)) r = '0;
      else r = SLOT_W'(s + 1'b1);
      return r;
   endfunction

   function automatic addr_type byte_addr(input slot_type s, input fill_type idx);
      return ADDR_W'(ADDR_W'(s) * ADDR_W'(CHUNK_SIZE) + ADDR_W'(idx));
   endfunction

   // chunks held, low 3 bits
   function automatic logic [2:0] chunk_count(input slot_type ws, input slot_type rs);
      logic [SUM_W-1:0] d;
      d = SUM_W'(ws) + SUM_W'(CHUNK_NUM) - SUM_W'(rs);
      if (d >= SUM_W'(CHUNK_NUM)) d = SUM_W'(d - SUM_W'(CHUNK_NUM));
      return d[2:0];
   endfunction

   function automatic logic [5:0] len_field(input fill_type len);
      logic [LENX_W-1:0] x;
      x = LENX_W'(len);
      return x[5:0];
   endfunction

endpackage

`default_nettype wire

[rtl/cfr_byte_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module cfr_byte_mem
   import cfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       we,
   input  wire addr_type   waddr,
   input  wire logic [7:0] wdata,
   input  wire logic       re,
   input  wire addr_type   raddr,
   output logic [7:0]      rdata
);

   logic [7:0] mem [0:BYTES-1];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/cfr_desc_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module cfr_desc_mem
   import cfr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     we,
   input  wire slot_type waddr,
   input  wire desc_type wdata,
   input  wire logic     re,
   input  wire slot_type raddr,
   output desc_type      rdata
);

   desc_type mem [0:CHUNK_NUM-1];
   desc_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/chunk_ring_fifo.sv]
// channel   ports                       handshake
// request   req_item, start, busy       taken when start is high and busy low
// result    rsp_item, rsp_valid         each result shown for a single cycle, no backpressure
//
// a push byte leaves busy low, so bytes stream one per cycle.
// a pop of an n-byte chunk keeps busy high while its n bytes stream out, one
// byte a cycle from the single read port of the byte memory; an empty pop leaves busy low.
// results are registered in rsp_item behind the transaction (or the registered memory read data) that causes them.
// reset clears the slot pointers, fill index and strobe; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module chunk_ring_fifo
   import cfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_STREAM = 2'b10
   } state_type;

   state_type state_ff, state_in;
   slot_type  ws_ff, ws_in;
   slot_type  rs_ff, rs_in;
   slot_type  pop_slot_ff, pop_slot_in;
   fill_type  fill_ff, fill_in;
   fill_type  idx_ff, idx_in;
   logic      drop_ff, drop_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   logic      byte_we, byte_re;
   addr_type  byte_waddr, byte_raddr;
   logic [7:0] byte_rdata;
   logic      desc_we, desc_re;
   desc_type  desc_wdata, desc_rdata;

   logic      accept;
   logic      drop_now;
   fill_type  fill_inc;
   fill_type  idx_next;
   logic      stream_last;

   assign busy   = (state_ff == S_STREAM);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      ws_in        = ws_ff;
      rs_in        = rs_ff;
      pop_slot_in  = pop_slot_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      drop_in      = drop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      byte_we      = 1'b0;
      byte_waddr   = byte_addr(ws_ff, fill_ff);
      byte_re      = 1'b0;
      byte_raddr   = byte_addr(rs_ff, '0);
      desc_we      = 1'b0;
      desc_wdata   = '{len: '0, src_id: req_item.in_media_id};
      desc_re      = 1'b0;

      // full check is made on the first byte only and held for the chunk
      drop_now = (fill_ff == '0) ? (slot_next(ws_ff) == rs_ff) : drop_ff;
      fill_inc = (fill_ff <= FILL_W'(CHUNK_SIZE)) ? FILL_W'(fill_ff + 1'b1) : fill_ff;
      idx_next = FILL_W'(idx_ff + 1'b1);
      stream_last = (idx_next == desc_rdata.len);

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_item.op == OP_PUSH) begin
               byte_we = !drop_now && (fill_ff < FILL_W'(CHUNK_SIZE));
               if (req_item.in_last) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.out_last = 1'b1;
                  if (fill_inc > FILL_W'(CHUNK_SIZE)) begin
                     rsp_in.status = ST_TOO_LONG;
                  end else if (drop_now) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status  = ST_STORED;
                     desc_we        = 1'b1;
                     desc_wdata.len = fill_inc;
                     ws_in          = slot_next(ws_ff);
                  end
                  fill_in = '0;
                  drop_in = 1'b0;
               end else begin
                  fill_in = fill_inc;
                  drop_in = drop_now;
               end
            end else if (accept) begin
               if (ws_ff == rs_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.status   = ST_EMPTY;
                  rsp_in.out_last = 1'b1;
               end else begin
                  desc_re     = 1'b1;
                  byte_re     = 1'b1;
                  pop_slot_in = rs_ff;
                  rs_in       = slot_next(rs_ff);
                  idx_in      = '0;
                  state_in    = S_STREAM;
               end
            end
         end
         S_STREAM: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = ST_POP_BYTE;
            rsp_in.out_byte     = byte_rdata;
            rsp_in.out_media_id = desc_rdata.src_id;
            rsp_in.out_len      = len_field(desc_rdata.len);
            rsp_in.out_last     = stream_last;
            idx_in              = idx_next;
            if (stream_last) begin
               state_in = S_IDLE;
            end else begin
               byte_re    = 1'b1;
               byte_raddr = byte_addr(pop_slot_ff, idx_next);
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_in.stored_count = chunk_count(ws_in, rs_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ws_ff        <= '0;
         rs_ff        <= '0;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         rs_ff        <= rs_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_slot_ff <= pop_slot_in;
      idx_ff      <= idx_in;
      rsp_ff      <= rsp_in;
   end

   cfr_byte_mem u_byte_mem (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (req_item.in_byte),
      .re    (byte_re),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   cfr_desc_mem u_desc_mem (
      .clock (clock),
      .we    (desc_we),
      .waddr (ws_ff),
      .wdata (desc_wdata),
      .re    (desc_re),
      .raddr (rs_ff),
      .rdata (desc_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire
